FILE: rtl/prnc_pkg.sv
`default_nettype none
package prnc_pkg;

  // Source palette size, fixed by the 11-bit source index.
  localparam int SRC_COLOURS = 2048;
  localparam int MAP_AW      = 11;

  // Colour components are 5 bits each in an xBGR555 word.
  localparam int COMP_W   = 5;
  localparam int COLOUR_W = 15;

  // Largest squared distance is 3 * 31 * 31 = 2883.
  localparam int DIST_W = 12;

  // Width of a reduced index as stored in the map and shown at the output.
  localparam int SLOT_W = 8;

  // Frame tag kept with each map entry. Tag zero never matches.
  localparam int EPOCH_W = 6;

  typedef logic [COLOUR_W-1:0] colour_t;
  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [EPOCH_W-1:0]  epoch_t;

  typedef struct packed {
    epoch_t            tag;
    logic [SLOT_W-1:0] slot;
  } map_entry_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_SEARCH,
    ST_FINISH,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/prnc_dist.sv
`default_nettype none
module prnc_dist
  import prnc_pkg::*;
(
  input  wire colour_t a,
  input  wire colour_t b,
  output dist_t        distance
);

  logic [COMP_W-1:0]   a_c [3];
  logic [COMP_W-1:0]   b_c [3];
  logic [COMP_W-1:0]   diff [3];
  logic [2*COMP_W-1:0] sq [3];

  // Absolute difference and square per component.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_c[k]  = a[k*COMP_W +: COMP_W];
      b_c[k]  = b[k*COMP_W +: COMP_W];
      diff[k] = (a_c[k] > b_c[k]) ? (a_c[k] - b_c[k]) : (b_c[k] - a_c[k]);
      sq[k]   = (2*COMP_W)'(diff[k]) * (2*COMP_W)'(diff[k]);
    end
  end

  // Sum of the three squares.
  assign distance = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);

endmodule
`default_nettype wire

FILE: rtl/palette_reduce_nearest_colour.sv
`default_nettype none
// Per-frame palette reduction. Each input item is one pixel: a source index
// and its xBGR555 colour. Each item gives one result item: the reduced index
// and the number of slots allocated so far in the frame.
// Both channels use valid/ready. in_ready is high only while the block is
// idle; one item is worked on at a time.
// A map hit or a miss that takes a free slot goes through the LOOKUP, CHECK
// and EMIT states to out_valid, and the next item is accepted once the block
// is back in idle. A miss with a full palette scans every stored slot through
// one distance unit, one slot per cycle, and then passes FINISH and EMIT.
// The scan rate is set by the single read port of the slot memory.
// The source map is a memory tagged with a frame number, so a frame start
// costs nothing, except every 63rd one, which first rewrites all 2048 map
// entries before the pixel is handled.
// After reset the same clearing pass runs with in_ready low.
// The result sits in an output register; while the receiver stalls, the block
// can accept and work on the next item, and holds it ready until the output
// register frees.
module palette_reduce_nearest_colour
  import prnc_pkg::*;
#(
  parameter int OUT_COLOURS = 256
)(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_frame_start,
  input  wire [10:0] in_source_index,
  input  wire [15:0] in_colour_word,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_index,
  output logic [8:0] out_slots_used
);

  localparam int SLOT_AW = $clog2(OUT_COLOURS);
  localparam int CNT_W   = $clog2(OUT_COLOURS + 1);

  // Memories.
  map_entry_t map_mem [SRC_COLOURS];
  colour_t    col_mem [OUT_COLOURS];

  state_t state_r, state_nxt;

  epoch_t              epoch_r, epoch_nxt;
  logic [MAP_AW-1:0]   idx_r, idx_nxt;
  colour_t             colour_r, colour_nxt;
  logic [MAP_AW-1:0]   clr_r, clr_nxt;
  logic                pend_r, pend_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    iss_r, iss_nxt;
  logic                p1_v_r, p1_v_nxt;
  logic [SLOT_AW-1:0]  p1_i_r, p1_i_nxt;
  logic                p2_v_r;
  logic [SLOT_AW-1:0]  p2_i_r;
  dist_t               p2_d_r;
  logic [SLOT_AW-1:0]  best_r, best_nxt;
  dist_t               best_d_r, best_d_nxt;
  logic [SLOT_W-1:0]   res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_index_r, out_index_nxt;
  logic [8:0]          out_slots_r, out_slots_nxt;

  map_entry_t          map_q_r;
  colour_t             col_q_r;
  dist_t               scan_dist;

  logic                map_we;
  logic [MAP_AW-1:0]   map_waddr;
  map_entry_t          map_wdata;
  logic                col_we;

  logic                accept;
  logic                hit;
  logic                has_free;
  logic                issuing;
  logic                scan_last;
  logic                emit_go;

  assign accept    = in_valid && in_ready;
  assign hit       = (map_q_r.tag == epoch_r);
  assign has_free  = (count_r < CNT_W'(OUT_COLOURS));
  assign issuing   = (state_r == ST_SEARCH) && (iss_r < CNT_W'(OUT_COLOURS));
  assign scan_last = p2_v_r && (p2_i_r == SLOT_AW'(OUT_COLOURS - 1));
  assign emit_go   = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == MAP_AW'(SRC_COLOURS - 1)) begin
          state_nxt = pend_r ? ST_LOOKUP : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_frame_start && (epoch_r == '1)) begin
            state_nxt = ST_CLEAR;
          end else begin
            state_nxt = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (hit || has_free) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (scan_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and next values.
  always_comb begin
    epoch_nxt     = epoch_r;
    idx_nxt       = idx_r;
    colour_nxt    = colour_r;
    clr_nxt       = clr_r;
    pend_nxt      = pend_r;
    count_nxt     = count_r;
    iss_nxt       = iss_r;
    best_nxt      = best_r;
    best_d_nxt    = best_d_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_index_nxt = out_index_r;
    out_slots_nxt = out_slots_r;
    map_we        = 1'b0;
    map_waddr     = idx_r;
    map_wdata     = '{tag: epoch_r, slot: '0};
    col_we        = 1'b0;
    p1_v_nxt      = issuing;
    p1_i_nxt      = iss_r[SLOT_AW-1:0];
    case (state_r)
      ST_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        map_wdata = '{tag: '0, slot: '0};
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == MAP_AW'(SRC_COLOURS - 1)) begin
          pend_nxt = 1'b0;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          idx_nxt    = in_source_index;
          colour_nxt = in_colour_word[COLOUR_W-1:0];
          if (in_frame_start) begin
            count_nxt = '0;
            if (epoch_r == '1) begin
              epoch_nxt = epoch_t'(1);
              clr_nxt   = '0;
              pend_nxt  = 1'b1;
            end else begin
              epoch_nxt = epoch_r + 1'b1;
            end
          end
        end
      end
      ST_CHECK: begin
        if (hit) begin
          res_nxt = map_q_r.slot;
        end else if (has_free) begin
          // Take the next free slot and store its colour.
          col_we    = 1'b1;
          map_we    = 1'b1;
          map_wdata = '{tag: epoch_r, slot: SLOT_W'(count_r[SLOT_AW-1:0])};
          res_nxt   = SLOT_W'(count_r[SLOT_AW-1:0]);
          count_nxt = count_r + 1'b1;
        end else begin
          iss_nxt = '0;
        end
      end
      ST_SEARCH: begin
        if (issuing) begin
          iss_nxt = iss_r + 1'b1;
        end
        // Keep the first slot, then only a strictly closer one.
        if (p2_v_r && ((p2_i_r == '0) || (p2_d_r < best_d_r))) begin
          best_nxt   = p2_i_r;
          best_d_nxt = p2_d_r;
        end
      end
      ST_FINISH: begin
        map_we    = 1'b1;
        map_wdata = '{tag: epoch_r, slot: SLOT_W'(best_r)};
        res_nxt   = SLOT_W'(best_r);
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = res_r;
          out_slots_nxt = 9'(count_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Shared distance unit for the nearest-colour scan.
  prnc_dist u_dist (
    .a        (col_q_r),
    .b        (colour_r),
    .distance (scan_dist)
  );

  // Source map memory: one write port, registered read of the current pixel.
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    map_q_r <= map_mem[idx_r];
  end

  // Slot colour memory: written on allocation, read one slot a cycle by the scan.
  always_ff @(posedge clk) begin
    if (col_we) begin
      col_mem[count_r[SLOT_AW-1:0]] <= colour_r;
    end
    col_q_r <= col_mem[iss_r[SLOT_AW-1:0]];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      epoch_r     <= epoch_t'(1);
      clr_r       <= '0;
      pend_r      <= 1'b0;
      count_r     <= '0;
      iss_r       <= '0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      epoch_r     <= epoch_nxt;
      clr_r       <= clr_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      iss_r       <= iss_nxt;
      p1_v_r      <= p1_v_nxt;
      p2_v_r      <= p1_v_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    colour_r    <= colour_nxt;
    p1_i_r      <= p1_i_nxt;
    p2_i_r      <= p1_i_r;
    p2_d_r      <= scan_dist;
    best_r      <= best_nxt;
    best_d_r    <= best_d_nxt;
    res_r       <= res_nxt;
    out_index_r <= out_index_nxt;
    out_slots_r <= out_slots_nxt;
  end

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_index      = out_index_r;
  assign out_slots_used = out_slots_r;

endmodule
`default_nettype wire
